// File: src/nd_constant_pad_address_gen_core_macros.svh
// Assertion macros for the constant pad address generator.
`ifndef ND_CONSTANT_PAD_ADDRESS_GEN_CORE_MACROS_SVH
`define ND_CONSTANT_PAD_ADDRESS_GEN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDPAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NDPAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ndpad_pkg.sv
// Shared constants, register codes and types of the constant pad address generator.
`default_nettype none
package ndpad_pkg;

  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_COORD_BITS = 16;
  localparam int PACKED_DIMS    = 4;   // dims carried in the packed registers
  localparam int FIELD_BITS     = 16;  // one packed size or pad
  localparam int IDX_BITS       = 32;  // strides and source index
  localparam int FILL_BITS      = 64;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_IDX_BITS   = 3;
  localparam int DCNT_BITS      = 3;
  localparam int NUSED_BITS     = 4;   // holds up to 15 dims

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIM_COUNT   = 3'd0,
    REG_IN_SIZES    = 3'd1,
    REG_PADS_BEFORE = 3'd2,
    REG_PADS_AFTER  = 3'd3,
    REG_FILL_VALUE  = 3'd4
  } cfg_reg_t;

  // Per-dimension status handed from a cell to the top level.
  typedef struct packed {
    logic empty;    // output size <= 0
    logic oor;      // source coordinate outside the input
    logic at_last;  // coordinate is the last of its dimension
    logic carry;    // this cell wraps and carries into the next
  } cell_stat_t;

endpackage
`default_nettype wire

// File: src/ndpad_if.sv
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none
interface ndpad_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ndpad_out_if;
  import ndpad_pkg::*;
  logic                valid;
  logic                ready;
  logic                is_fill;
  logic [IDX_BITS-1:0] src_index;
  logic [FILL_BITS-1:0] fill_out;
  logic                last;

  modport source (output valid, output is_fill, output src_index, output fill_out,
                  output last, input ready);
  modport sink   (input valid, input is_fill, input src_index, input fill_out,
                  input last, output ready);
endinterface
`default_nettype wire

// File: src/nd_constant_pad_address_gen_core.sv
// Top level of the N-dimensional constant pad address generator.
//
//   channel  dir  handshake            payload
//   in_bus   in   valid/ready          restart
//   out_bus  out  valid/ready          is_fill, src_index, fill_out, last
//   cfg_*    in   cfg_we (no stall)    cfg_index, cfg_data
//
// One beat per clock sustained while out_bus takes results and no settle is pending;
// a result passes the coordinate/range, per-dimension multiply and index sum stages.
// The coordinate carry ripples through the cell row within the accept cycle.
// After reset and after every cfg write, in_bus.ready stays low until the settle
// counter runs out, while the stride chain (one 32x16 multiply per cell) settles.
// Reset is synchronous, active low. A stall on out_bus backs up stage by
// stage; empty slots in the pipe keep accepting beats meanwhile.
`default_nettype none
`include "nd_constant_pad_address_gen_core_macros.svh"
module nd_constant_pad_address_gen_core #(
  parameter int MAX_DIMS   = ndpad_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = ndpad_pkg::DEF_COORD_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ndpad_in_if.sink                                 in_bus,
  ndpad_out_if.source                              out_bus,
  input  wire logic                                cfg_we,
  input  wire logic [ndpad_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ndpad_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ndpad_pkg::*;

  localparam int SETTLE_BITS = $clog2(MAX_DIMS + 1);

  // configuration registers
  logic [DCNT_BITS-1:0]                    dim_count_r;
  logic [PACKED_DIMS-1:0][FIELD_BITS-1:0]  in_sizes_r, pads_before_r, pads_after_r;
  logic [FILL_BITS-1:0]                    fill_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r   <= DCNT_BITS'(1);
      in_sizes_r    <= '0;
      pads_before_r <= '0;
      pads_after_r  <= '0;
      fill_value_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_COUNT:   dim_count_r   <= cfg_data[DCNT_BITS-1:0];
        REG_IN_SIZES:    in_sizes_r    <= cfg_data;
        REG_PADS_BEFORE: pads_before_r <= cfg_data;
        REG_PADS_AFTER:  pads_after_r  <= cfg_data;
        REG_FILL_VALUE:  fill_value_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off input while strides and output sizes settle
  logic [SETTLE_BITS-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_BITS'(MAX_DIMS);
    end else if (cfg_we) begin
      settle_r <= SETTLE_BITS'(MAX_DIMS);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_BITS'(1);
    end
  end

  // dims in use: 0 acts as 1, clamp at MAX_DIMS
  logic [NUSED_BITS-1:0] n_used;
  logic [MAX_DIMS-1:0]   used;

  always_comb begin
    if (dim_count_r == '0) begin
      n_used = NUSED_BITS'(1);
    end else if ({1'b0, dim_count_r} > NUSED_BITS'(MAX_DIMS)) begin
      n_used = NUSED_BITS'(MAX_DIMS);
    end else begin
      n_used = {1'b0, dim_count_r};
    end
  end

  // pipeline control
  logic a_valid_r, a_fill_r, a_last_r;
  logic b_valid_r, b_fill_r, b_last_r;
  logic out_take, b_load, a_load, in_ready, accept, advance;
  logic empty_any, fill_any, last_all;

  assign b_load   = !b_valid_r || out_take;
  assign a_load   = !a_valid_r || b_load;
  assign in_ready = a_load && (settle_r == '0);
  assign accept   = in_bus.valid && in_ready;
  assign advance  = accept && !empty_any;
  assign in_bus.ready = in_ready;

  // cell row
  logic [MAX_DIMS:0][IDX_BITS-1:0]   stride_link;
  logic [MAX_DIMS:0]                 carry_link;
  logic [MAX_DIMS-1:0][IDX_BITS-1:0] prod;
  cell_stat_t [MAX_DIMS-1:0]         stat;
  logic [MAX_DIMS-1:0]               empty_v, oor_v, last_v;

  assign stride_link[0] = IDX_BITS'(1);
  assign carry_link[0]  = 1'b1;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    logic [FIELD_BITS-1:0]        size_d;
    logic signed [FIELD_BITS-1:0] pb_d, pa_d;

    // dims past the packed registers have size 1 and no padding
    if (d < PACKED_DIMS) begin : g_packed
      assign size_d = in_sizes_r[d];
      assign pb_d   = $signed(pads_before_r[d]);
      assign pa_d   = $signed(pads_after_r[d]);
    end else begin : g_fixed
      assign size_d = FIELD_BITS'(1);
      assign pb_d   = '0;
      assign pa_d   = '0;
    end

    assign used[d] = (NUSED_BITS'(d) < n_used);

    ndpad_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .size_i       (size_d),
      .pad_before_i (pb_d),
      .pad_after_i  (pa_d),
      .stride_i     (stride_link[d]),
      .stride_o     (stride_link[d+1]),
      .used_i       (used[d]),
      .carry_i      (carry_link[d]),
      .accept_i     (accept),
      .restart_i    (in_bus.restart),
      .advance_i    (advance),
      .a_load_i     (a_load),
      .b_load_i     (b_load),
      .stat_o       (stat[d]),
      .prod_o       (prod[d])
    );

    assign carry_link[d+1] = stat[d].carry;
    assign empty_v[d]      = used[d] && stat[d].empty;
    assign oor_v[d]        = used[d] && stat[d].oor;
    assign last_v[d]       = !used[d] || stat[d].at_last;
  end

  assign empty_any = |empty_v;
  assign fill_any  = |oor_v;
  assign last_all  = &last_v;

  // stage A: range and last flags, then stage B; an empty output makes no beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= accept && !empty_any;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_fill_r <= fill_any;
      a_last_r <= last_all;
    end
    if (b_load) begin
      b_fill_r <= a_fill_r;
      b_last_r <= a_last_r;
    end
  end

  // stage C: index sum and result register
  ndpad_sum #(
    .MAX_DIMS (MAX_DIMS)
  ) u_sum (
    .clk          (clk),
    .rst_n        (rst_n),
    .b_valid_i    (b_valid_r),
    .b_fill_i     (b_fill_r),
    .b_last_i     (b_last_r),
    .prod_i       (prod),
    .fill_value_i (fill_value_r),
    .take_o       (out_take),
    .out_bus      (out_bus)
  );

  `NDPAD_ASSERT_NOW(a_settle_blocks, clk, rst_n, settle_r != '0, !in_bus.ready, "input taken while strides settle")
  `NDPAD_ASSERT_NEXT(a_cfg_blocks, clk, rst_n, cfg_we, !in_bus.ready, "input taken right after a cfg write")
  `NDPAD_ASSERT_NOW(a_fill_no_index, clk, rst_n, out_bus.valid && out_bus.is_fill, out_bus.src_index == '0, "fill beat carries a source index")
  `NDPAD_ASSERT_NEXT(a_stage_a_held, clk, rst_n, a_valid_r && !b_load, a_valid_r, "stage A beat dropped under stall")
  `NDPAD_ASSERT_NEXT(a_stage_b_held, clk, rst_n, b_valid_r && !out_take, b_valid_r, "stage B beat dropped under stall")

endmodule
`default_nettype wire

// File: src/ndpad_cell.sv
// One dimension cell: coordinate counter, output size, stride link and index product.
`default_nettype none
module ndpad_cell #(
  parameter int COORD_BITS = ndpad_pkg::DEF_COORD_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [ndpad_pkg::FIELD_BITS-1:0]      size_i,
  input  wire logic signed [ndpad_pkg::FIELD_BITS-1:0] pad_before_i,
  input  wire logic signed [ndpad_pkg::FIELD_BITS-1:0] pad_after_i,
  input  wire logic [ndpad_pkg::IDX_BITS-1:0]        stride_i,
  output      logic [ndpad_pkg::IDX_BITS-1:0]        stride_o,
  input  wire logic                                  used_i,
  input  wire logic                                  carry_i,
  input  wire logic                                  accept_i,
  input  wire logic                                  restart_i,
  input  wire logic                                  advance_i,
  input  wire logic                                  a_load_i,
  input  wire logic                                  b_load_i,
  output      ndpad_pkg::cell_stat_t                 stat_o,
  output      logic [ndpad_pkg::IDX_BITS-1:0]        prod_o
);
  import ndpad_pkg::*;

  localparam int OSZ_LIMIT = 1 << COORD_BITS;
  localparam int SW = FIELD_BITS + 2;

  logic [COORD_BITS-1:0] coord_r, coord_nxt, c_eff;
  logic [COORD_BITS:0]   osz_r, osz_nxt, inc;
  logic                  empty_r, empty_nxt;
  logic [IDX_BITS-1:0]   stride_r;
  logic [FIELD_BITS-1:0] i_r, i_nxt;
  logic [IDX_BITS-1:0]   prod_r;
  logic signed [SW-1:0]  osz_s, src_s;
  logic                  oor, wrap;

  // output size from the config registers; osz_r registers it
  always_comb begin
    osz_s = $signed({2'b00, size_i}) + SW'(pad_before_i) + SW'(pad_after_i);
    empty_nxt = (osz_s <= $signed(SW'(0)));
    if (osz_s > $signed(SW'(OSZ_LIMIT))) begin
      osz_nxt = (COORD_BITS+1)'(OSZ_LIMIT);
    end else begin
      osz_nxt = osz_s[COORD_BITS:0];
    end
  end

  always_comb begin
    c_eff = restart_i ? '0 : coord_r;
    src_s = $signed({{(SW-COORD_BITS){1'b0}}, c_eff}) - SW'(pad_before_i);
    oor   = src_s[SW-1] || (src_s[SW-2:0] >= {1'b0, size_i});
    i_nxt = (used_i && !oor) ? src_s[FIELD_BITS-1:0] : '0;
    inc   = {1'b0, c_eff} + (COORD_BITS+1)'(1);
    wrap  = (inc >= osz_r);
    if (advance_i && used_i && carry_i) begin
      coord_nxt = wrap ? '0 : inc[COORD_BITS-1:0];
    end else begin
      coord_nxt = c_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else if (accept_i) begin
      coord_r <= coord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    osz_r    <= osz_nxt;
    empty_r  <= empty_nxt;
    stride_r <= stride_i;
    if (a_load_i) begin
      i_r <= i_nxt;
    end
    if (b_load_i) begin
      prod_r <= IDX_BITS'(i_r * stride_r);
    end
  end

  assign stride_o       = IDX_BITS'(stride_r * size_i);
  assign stat_o.empty   = empty_r;
  assign stat_o.oor     = oor;
  assign stat_o.at_last = ({1'b0, c_eff} == (osz_r - (COORD_BITS+1)'(1)));
  assign stat_o.carry   = carry_i && wrap;
  assign prod_o         = prod_r;

endmodule
`default_nettype wire

// File: src/ndpad_sum.sv
// Index sum over the dimension products and the registered result beat.
`default_nettype none
module ndpad_sum #(
  parameter int MAX_DIMS = ndpad_pkg::DEF_MAX_DIMS
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         b_valid_i,
  input  wire logic                                         b_fill_i,
  input  wire logic                                         b_last_i,
  input  wire logic [MAX_DIMS-1:0][ndpad_pkg::IDX_BITS-1:0] prod_i,
  input  wire logic [ndpad_pkg::FILL_BITS-1:0]              fill_value_i,
  output      logic                                         take_o,
  ndpad_out_if.source                                       out_bus
);
  import ndpad_pkg::*;

  logic                 out_valid_r;
  logic                 is_fill_r, last_r;
  logic [IDX_BITS-1:0]  src_r, sum;
  logic [FILL_BITS-1:0] fill_out_r;

  always_comb begin
    sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum = sum + prod_i[d];
    end
  end

  assign take_o = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_o) begin
      out_valid_r <= b_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      is_fill_r  <= b_fill_i;
      last_r     <= b_last_i;
      src_r      <= b_fill_i ? '0 : sum;
      fill_out_r <= b_fill_i ? fill_value_i : '0;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.is_fill   = is_fill_r;
  assign out_bus.src_index = src_r;
  assign out_bus.fill_out  = fill_out_r;
  assign out_bus.last      = last_r;

endmodule
`default_nettype wire

// File: bench/ndpad_walk_checker.sv
// Checker for the pad address generator: tracks the walk and checks each result beat.
module ndpad_walk_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  ndpad_in_if                                 in_mon,
  ndpad_out_if                                out_mon,
  input  logic                                cfg_we,
  input  logic [ndpad_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ndpad_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                  mismatch_count,
  output int                                  results_owed
);
  import ndpad_pkg::*;

  localparam int NDIM     = DEF_MAX_DIMS;
  localparam int SIZE_CAP = 1 << DEF_COORD_BITS;

  typedef struct packed {
    logic                 is_fill;
    logic [IDX_BITS-1:0]  src_index;
    logic [FILL_BITS-1:0] fill_out;
    logic                 last;
  } pad_elem_t;

  logic [DCNT_BITS-1:0]      dim_count_r;
  logic [CFG_DATA_BITS-1:0]  sizes_r;
  logic [CFG_DATA_BITS-1:0]  before_r;
  logic [CFG_DATA_BITS-1:0]  after_r;
  logic [FILL_BITS-1:0]      fill_r;
  logic [DEF_COORD_BITS-1:0] coord_r [NDIM];
  logic [IDX_BITS-1:0]       stride_r [NDIM];
  pad_elem_t                 owed_q [$];

  function automatic int dims_in_use();
    int n;
    n = int'(dim_count_r);
    if (n == 0) n = 1;
    if (n > NDIM) n = NDIM;
    return n;
  endfunction

  function automatic int field_size(int d);
    return int'(sizes_r[FIELD_BITS*d +: FIELD_BITS]);
  endfunction

  function automatic int field_pad(logic [CFG_DATA_BITS-1:0] word, int d);
    logic signed [FIELD_BITS-1:0] p;
    p = word[FIELD_BITS*d +: FIELD_BITS];
    return int'(p);
  endfunction

  // strides are products of the inner sizes, wrapping at 32 bits
  task automatic refresh_strides();
    logic [IDX_BITS-1:0] acc;
    acc = IDX_BITS'(1);
    for (int d = 0; d < NDIM; d++) begin
      if (d < dims_in_use()) begin
        stride_r[d] = acc;
        acc = acc * IDX_BITS'(field_size(d));
      end else begin
        stride_r[d] = '0;
      end
    end
  endtask

  // one input beat: evaluate the held coordinate, then step the odometer
  task automatic step_walk(input logic restart, output bit produced, output pad_elem_t elem);
    int                  n;
    int                  c;
    int                  i;
    int                  s;
    int                  osz [NDIM];
    bit                  empty;
    bit                  fill;
    bit                  at_last;
    bit                  carry;
    logic [IDX_BITS-1:0] src;
    n        = dims_in_use();
    produced = 1'b0;
    elem     = '0;
    empty    = 1'b0;
    fill     = 1'b0;
    at_last  = 1'b1;
    carry    = 1'b1;
    src      = '0;
    if (restart) foreach (coord_r[d]) coord_r[d] = '0;
    for (int d = 0; d < n; d++) begin
      s = field_size(d) + field_pad(before_r, d) + field_pad(after_r, d);
      if (s <= 0) empty = 1'b1;
      osz[d] = (s > SIZE_CAP) ? SIZE_CAP : s;
    end
    if (!empty) begin
      for (int d = 0; d < n; d++) begin
        c = int'(coord_r[d]);
        i = c - field_pad(before_r, d);
        if (i < 0 || i >= field_size(d)) fill = 1'b1;
        else src = src + IDX_BITS'(i) * stride_r[d];
        if (c != osz[d] - 1) at_last = 1'b0;
      end
      elem.is_fill   = fill;
      elem.src_index = fill ? '0 : src;
      elem.fill_out  = fill ? fill_r : '0;
      elem.last      = at_last;
      produced       = 1'b1;
      for (int d = 0; d < n; d++) begin
        if (carry) begin
          c = int'(coord_r[d]) + 1;
          if (c >= osz[d]) begin
            coord_r[d] = '0;
          end else begin
            coord_r[d] = DEF_COORD_BITS'(c);
            carry      = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    pad_elem_t seen;
    pad_elem_t want;
    bit        produced;
    if (!rst_n) begin
      dim_count_r = DCNT_BITS'(1);
      sizes_r     = '0;
      before_r    = '0;
      after_r     = '0;
      fill_r      = '0;
      foreach (coord_r[d]) coord_r[d] = '0;
      owed_q.delete();
      mismatch_count = 0;
      results_owed   = 0;
      refresh_strides();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.is_fill, out_mon.src_index, out_mon.fill_out, out_mon.last};
        if (owed_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat: fill=%0b idx=%h value=%h last=%0b",
                               seen.is_fill, seen.src_index, seen.fill_out, seen.last));
        end else begin
          want = owed_q.pop_front();
          if (seen.is_fill !== want.is_fill || seen.src_index !== want.src_index ||
              seen.fill_out !== want.fill_out || seen.last !== want.last)
            flag_error($sformatf({"result mismatch: expected fill=%0b idx=%h value=%h last=%0b,",
                                  " got fill=%0b idx=%h value=%h last=%0b"},
                                 want.is_fill, want.src_index, want.fill_out, want.last,
                                 seen.is_fill, seen.src_index, seen.fill_out, seen.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM_COUNT:   dim_count_r = cfg_data[DCNT_BITS-1:0];
          REG_IN_SIZES:    sizes_r     = cfg_data;
          REG_PADS_BEFORE: before_r    = cfg_data;
          REG_PADS_AFTER:  after_r     = cfg_data;
          REG_FILL_VALUE:  fill_r      = cfg_data;
          default: ;
        endcase
        refresh_strides();
      end
      if (in_mon.valid && in_mon.ready) begin
        step_walk(in_mon.restart, produced, want);
        if (produced) owed_q.push_back(want);
      end
      results_owed = owed_q.size();
    end
  end

endmodule

// File: bench/tb_nd_constant_pad_address_gen_core.sv
// Testbench top for the constant pad address generator: stimulus, stalls and verdict.
module tb_nd_constant_pad_address_gen_core;
  import ndpad_pkg::*;

  localparam int NDIM           = DEF_MAX_DIMS;
  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_CYCLES    = 300;           // long receiver hold-off
  localparam int SETTLE_CYCLES  = 3 + NDIM + 5;  // pipe depth + stride settle + margin
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;          // cycles with no beat on either side
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;  // index that decodes to nothing

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       mismatch_count;
  int                       results_owed;
  int                       hold_requests = 0;  // bumped by the sender, served by the receiver
  int                       idle_cycles = 0;

  ndpad_in_if  in_ch ();
  ndpad_out_if out_ch ();

  nd_constant_pad_address_gen_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ndpad_walk_checker u_walk_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #1 clk = ~clk;

  // Gap length: mostly from the shortest band, some from a medium band, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // Register write; inputs move on the falling edge only.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Tensor shape: dim count plus the three packed size/pad words.
  // Upper bits of the dim count write carry noise; the block must mask them.
  task automatic load_shape(input int dcount, input int sz[NDIM],
                            input int pb[NDIM], input int pa[NDIM]);
    logic [CFG_DATA_BITS-1:0] wsz;
    logic [CFG_DATA_BITS-1:0] wpb;
    logic [CFG_DATA_BITS-1:0] wpa;
    wsz = '0;
    wpb = '0;
    wpa = '0;
    for (int d = 0; d < NDIM; d++) begin
      wsz[FIELD_BITS*d +: FIELD_BITS] = FIELD_BITS'(sz[d]);
      wpb[FIELD_BITS*d +: FIELD_BITS] = FIELD_BITS'(pb[d]);
      wpa[FIELD_BITS*d +: FIELD_BITS] = FIELD_BITS'(pa[d]);
    end
    write_reg(REG_DIM_COUNT, (CFG_DATA_BITS'({$urandom, $urandom}) << DCNT_BITS) |
                             CFG_DATA_BITS'(dcount & 7));
    write_reg(REG_IN_SIZES, wsz);
    write_reg(REG_PADS_BEFORE, wpb);
    write_reg(REG_PADS_AFTER, wpa);
  endtask

  // One input beat, after 'gap' idle cycles. Valid stays up between
  // back-to-back beats; restart carries noise while valid is low.
  task automatic send_beat(input logic restart, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid   = 1'b0;
      in_ch.restart = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.restart = restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sender pauses until every owed result is back, then lets the pipe and
  // the stride chain settle: beats of an empty tensor leave no trace.
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls in some stretches, none in others, and a long
  // hold-off on request so the pipe fills and the input backs up.
  initial begin
    int stall_left;
    int mode_left;
    int hold_seen;
    bit steady;
    stall_left   = 0;
    mode_left    = 0;
    hold_seen    = 0;
    steady       = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen    = hold_requests;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left   = idle_len() - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sz [NDIM];
    int pb [NDIM];
    int pa [NDIM];
    int dc;
    int used;
    int phase;
    int sent;
    int beats;
    int gap;
    int pick;
    int wsz;
    int wpb;
    int wpa;
    bit burst;
    bit want_empty;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_DIM_COUNT;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // --- directed part ---

    // Reset state: every size is zero, so the tensor is empty and no
    // result may come out.
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    quiesce();

    // Dim count zero acts as one. Crop one in front, pad two behind:
    // two source elements, two fill, last on the fourth, then wrap.
    // A write to an unused index must change nothing.
    sz = '{3, 0, 0, 0};
    pb = '{-1, 0, 0, 0};
    pa = '{2, 0, 0, 0};
    load_shape(0, sz, pb, pa);
    write_reg(REG_FILL_VALUE, '1);
    write_reg(REG_SPARE, '1);
    send_beat(1'b1, 0);
    repeat (4) send_beat(1'b0, 0);
    quiesce();

    // Dim count above the limit acts as four. Inner dims are full-size
    // and cropped to a single element from the most negative pad, so the
    // strides wrap past 32 bits; the outer dim walks with one pad in front.
    sz = '{65535, 65535, 65535, 3};
    pb = '{-32768, -32768, -32768, 1};
    pa = '{-32766, -32766, -32766, 0};
    load_shape(7, sz, pb, pa);
    write_reg(REG_FILL_VALUE, 64'h0123_4567_89ab_cdef);
    send_beat(1'b1, 0);
    repeat (4) send_beat(1'b0, 2);
    quiesce();

    // Inner dim shifted completely out of its input: every element is
    // fill. No restart, so the walk carries on from the held coordinates.
    sz = '{2, 2, 0, 0};
    pb = '{-3, 0, 0, 0};
    pa = '{3, 0, 0, 0};
    load_shape(2, sz, pb, pa);
    write_reg(REG_FILL_VALUE, '0);
    repeat (3) send_beat(1'b0, 0);
    quiesce();

    // Mid-walk shrink: walk to coordinate five of six, then cut the size
    // to three. The held coordinate is fill, never last, and wraps.
    sz = '{6, 0, 0, 0};
    pb = '{0, 0, 0, 0};
    pa = '{0, 0, 0, 0};
    load_shape(1, sz, pb, pa);
    send_beat(1'b1, 0);
    repeat (4) send_beat(1'b0, 0);
    quiesce();
    sz[0] = 3;
    load_shape(1, sz, pb, pa);
    repeat (2) send_beat(1'b0, 0);
    quiesce();

    // Oversized output saturates at the coordinate range; largest pads.
    sz = '{65535, 0, 0, 0};
    pb = '{32767, 0, 0, 0};
    pa = '{32767, 0, 0, 0};
    load_shape(1, sz, pb, pa);
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    quiesce();

    // --- random part ---
    // Mostly small tensors walked end to end so last and the carries show
    // up often; some dims use full-range sizes and pads trimmed down to a
    // short output, an outer dim may saturate, and a few tensors are empty.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      dc         = $urandom_range(0, 7);
      used       = (dc == 0) ? 1 : ((dc > NDIM) ? NDIM : dc);
      want_empty = ($urandom_range(0, 19) == 0);
      for (int d = 0; d < NDIM; d++) begin
        pick  = $urandom_range(0, 19);
        sz[d] = $urandom_range(0, 6);
        pb[d] = int'($urandom_range(0, 6)) - 3;
        pa[d] = int'($urandom_range(1, 5)) - sz[d] - pb[d];
        if (d >= used) begin
          // unused dims get junk the block has to ignore
          sz[d] = $urandom_range(0, 65535);
          pb[d] = int'($urandom_range(0, 65535)) - 32768;
          pa[d] = int'($urandom_range(0, 65535)) - 32768;
        end else if (pick < 2 && d == used - 1) begin
          sz[d] = $urandom_range(60000, 65535);
          pb[d] = $urandom_range(30000, 32767);
          pa[d] = $urandom_range(30000, 32767);
        end else if (pick < 7) begin
          wsz = (pick == 2) ? 0 : ((pick == 3) ? 65535 : int'($urandom_range(0, 65535)));
          wpb = int'($urandom_range(0, 65535)) - 32768;
          wpa = int'($urandom_range(1, 4)) - wsz - wpb;
          if (wpa > 32767) wpa = 32767;
          if (wpa < -32768) wpa = -32768;
          if (wsz + wpb + wpa > 0) begin
            sz[d] = wsz;
            pb[d] = wpb;
            pa[d] = wpa;
          end
        end
      end
      if (want_empty) begin
        pick     = $urandom_range(0, used - 1);
        sz[pick] = $urandom_range(0, 3);
        pb[pick] = -int'($urandom_range(0, 3));
        pa[pick] = -(sz[pick] + pb[pick]) - int'($urandom_range(0, 3));
      end
      load_shape(dc, sz, pb, pa);
      if ($urandom_range(0, 1) == 1) write_reg(REG_FILL_VALUE, {$urandom, $urandom});

      beats = want_empty ? 4 : $urandom_range(20, 80);
      burst = ($urandom_range(0, 3) == 0);
      if (!want_empty && phase % 5 == 0) begin
        // receiver holds off while the sender keeps pushing
        hold_requests++;
        burst = 1'b1;
      end
      for (int k = 0; k < beats; k++) begin
        gap = (burst || $urandom_range(0, 9) >= 4) ? 0 : idle_len();
        send_beat((k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0), gap);
      end
      if (!want_empty) sent += beats;
      phase++;
      quiesce();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
